### hdl/asg_pkg.sv
// Shared constants and types for the ARMA series generator.
`timescale 1ns / 1ps

package asg_pkg;

   // Field and register widths fixed by the block definition
   localparam int ORDER_W    = 4;
   localparam int SLOT_W     = 4;
   localparam int COEF_W     = 18;
   localparam int FRAC_BITS  = 16;
   localparam int CNT_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // First coefficient slot of the moving average taps
   localparam logic [SLOT_W-1:0] MA_SLOT_BASE = 4'd8;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AR_ORDER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MA_ORDER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SELECT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_VALUE  = 3'd3;

   // Control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic load;  // load accumulator with the newest noise sample
      logic tap;   // a tap read is issued to the memories this cycle
      logic sub;   // the issued tap is a moving average tap
   } mac_ctl_type;

endpackage

### hdl/asg_ram.sv
// Synchronous single-write, single-read memory with per-entry valid bits.
`timescale 1ns / 1ps

module asg_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // Write and registered read of the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Track written entries; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### hdl/asg_mac.sv
// Shared multiply-accumulate with rounding and saturation of the sum.
`timescale 1ns / 1ps

module asg_mac #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  asg_pkg::mac_ctl_type                ctl,
   input  logic [SAMPLE_BITS-1:0]              load_value,
   input  logic [asg_pkg::COEF_W-1:0]          coef,
   input  logic [SAMPLE_BITS-1:0]              hist,
   output logic                                busy,
   output logic [SAMPLE_BITS-1:0]              result,
   output logic                                saturated
);

   localparam int PROD_W   = SAMPLE_BITS + asg_pkg::COEF_W;
   localparam int ACC_W    = PROD_W + 6;
   localparam int FRAC_TOP = asg_pkg::FRAC_BITS - 1;

   logic                          tap_d1_ff, tap_d2_ff;
   logic                          sub_d1_ff, sub_d2_ff;
   logic signed [asg_pkg::COEF_W-1:0] coef_s;
   logic signed [SAMPLE_BITS-1:0] hist_s;
   logic signed [PROD_W-1:0]      prod_in;
   logic [PROD_W-1:0]             prod_ff;
   logic [ACC_W-1:0]              prod_ext;
   logic [ACC_W-1:0]              acc_in, acc_ff;
   logic [ACC_W-1:0]              rnd;
   logic [ACC_W-SAMPLE_BITS-FRAC_TOP-1:0] top_bits;

   // Delay tap control to line up with memory data and the product register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_d1_ff <= 1'b0;
         tap_d2_ff <= 1'b0;
         sub_d1_ff <= 1'b0;
         sub_d2_ff <= 1'b0;
      end else begin
         tap_d1_ff <= ctl.tap;
         tap_d2_ff <= tap_d1_ff;
         sub_d1_ff <= ctl.sub;
         sub_d2_ff <= sub_d1_ff;
      end
   end

   // Multiply coefficient by history sample as memory data arrives
   assign coef_s  = coef;
   assign hist_s  = hist;
   assign prod_in = coef_s * hist_s;

   always_ff @(posedge clock) begin
      if (tap_d1_ff) begin
         prod_ff <= prod_in;
      end
   end

   // Load with the noise sample in Q.16, then add or subtract each product
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = {{(ACC_W-SAMPLE_BITS){load_value[SAMPLE_BITS-1]}}, load_value}
                  << asg_pkg::FRAC_BITS;
      end else if (tap_d2_ff) begin
         acc_in = sub_d2_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Round half up, then clip to the sample range
   assign rnd      = acc_ff + (ACC_W'(1) << FRAC_TOP);
   assign top_bits = rnd[ACC_W-1:SAMPLE_BITS+FRAC_TOP];

   always_comb begin
      saturated = !((&top_bits) || !(|top_bits));
      if (saturated) begin
         result = rnd[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                               : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         result = rnd[SAMPLE_BITS+FRAC_TOP:asg_pkg::FRAC_BITS];
      end
   end

   assign busy = tap_d1_ff | tap_d2_ff;

endmodule

### hdl/arma_series_generator.sv
// Top level of the ARMA(p,q) series generator: sequencer, registers, memories.
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall noise_sample, seed_value, series_start, series_last
// rsp      out        rsp_valid/rsp_stall series_value, saturated, is_last
// csr      in         csr_valid/csr_ready csr_index, csr_wdata
//
// A computed item goes through the issue, drain, history-write and emit steps (no issue
// step when both orders are zero); each tap is one read of the coefficient and history
// memories into the shared multiply-accumulate. No new item is taken until idle.
// A seed item goes through the history writes and emit; a warm-up item only writes noise.
// Reset clears control state and the memory valid bits; no clearing pass is needed.
// A stalled result holds the sequencer in its emit step until the output register frees.
module arma_series_generator #(
   parameter int MAX_AR      = 8,
   parameter int MAX_MA      = 8,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_noise_sample,
   input  logic [SAMPLE_BITS-1:0]            req_seed_value,
   input  logic                              req_series_start,
   input  logic                              req_series_last,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [SAMPLE_BITS-1:0]            rsp_series_value,
   output logic                              rsp_saturated,
   output logic                              rsp_is_last,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [asg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [asg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int MEM_DEPTH = MAX_AR + MAX_MA;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int AR_IW     = (MAX_AR > 1) ? $clog2(MAX_AR) : 1;
   localparam int MA_IW     = (MAX_MA > 1) ? $clog2(MAX_MA) : 1;
   localparam int CNT_W     = asg_pkg::CNT_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_WR_Y  = 3'd3;
   localparam logic [2:0] S_WR_E  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [asg_pkg::ORDER_W-1:0]     ar_order_ff, ma_order_ff;
   logic [asg_pkg::SLOT_W-1:0]      coef_select_ff;
   logic [CNT_W-1:0]                warmup_ff, warmup_in;
   logic [CNT_W-1:0]                tap_ff, tap_in;
   logic [CNT_W-1:0]                p_ff, p_in;
   logic [CNT_W-1:0]                n_ff, n_in;
   logic [AR_IW-1:0]                y_head_ff, y_head_in, y_ptr_ff, y_ptr_in, y_next;
   logic [MA_IW-1:0]                e_head_ff, e_head_in, e_ptr_ff, e_ptr_in, e_next;
   logic [SAMPLE_BITS-1:0]          noise_ff, noise_in;
   logic [SAMPLE_BITS-1:0]          value_ff, value_in;
   logic                            sat_ff, sat_in;
   logic                            last_ff, last_in;
   logic                            produce_ff, produce_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]          rsp_value_ff;
   logic                            rsp_sat_ff, rsp_last_ff;
   logic                            rsp_load;

   logic                            req_xfer, csr_xfer;
   logic [CNT_W-1:0]                p_eff, q_eff, pq_sum, cnt_eff;
   logic [asg_pkg::SLOT_W-1:0]      ma_slot;

   asg_pkg::mac_ctl_type            mac_ctl;
   logic                            mac_busy, mac_sat;
   logic [SAMPLE_BITS-1:0]          mac_result;

   logic                            hist_wr_en, hist_rd_en;
   logic [MEM_AW-1:0]               hist_wr_addr, hist_rd_addr;
   logic [SAMPLE_BITS-1:0]          hist_wr_data, hist_rd_data;
   logic                            coef_wr_en;
   logic [MEM_AW-1:0]               coef_wr_addr, coef_rd_addr;
   logic [asg_pkg::COEF_W-1:0]      coef_rd_data;

   assign req_xfer  = req_valid && !req_stall;
   assign csr_xfer  = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ar_order_ff    <= '0;
         ma_order_ff    <= '0;
         coef_select_ff <= '0;
      end else if (csr_xfer) begin
         case (csr_index)
            asg_pkg::CSR_AR_ORDER:    ar_order_ff    <= csr_wdata[asg_pkg::ORDER_W-1:0];
            asg_pkg::CSR_MA_ORDER:    ma_order_ff    <= csr_wdata[asg_pkg::ORDER_W-1:0];
            asg_pkg::CSR_COEF_SELECT: coef_select_ff <= csr_wdata[asg_pkg::SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   // Route a coefficient write to its slot; drop slots beyond MAX_AR and MAX_MA
   assign ma_slot = coef_select_ff - asg_pkg::MA_SLOT_BASE;

   always_comb begin
      coef_wr_en   = 1'b0;
      coef_wr_addr = MEM_AW'(coef_select_ff);
      if (csr_xfer && csr_index == asg_pkg::CSR_COEF_VALUE) begin
         if (coef_select_ff < asg_pkg::MA_SLOT_BASE) begin
            coef_wr_en = (coef_select_ff < MAX_AR);
         end else begin
            coef_wr_en   = (ma_slot < MAX_MA);
            coef_wr_addr = MEM_AW'(MAX_AR) + MEM_AW'(ma_slot);
         end
      end
   end

   // Effective orders and warm-up position of the arriving item
   assign p_eff   = (ar_order_ff > MAX_AR) ? CNT_W'(MAX_AR) : CNT_W'(ar_order_ff);
   assign q_eff   = (ma_order_ff > MAX_MA) ? CNT_W'(MAX_MA) : CNT_W'(ma_order_ff);
   assign pq_sum  = p_eff + q_eff;
   assign cnt_eff = req_series_start ? '0 : warmup_ff;

   // Ring buffer slot that the next push takes
   assign y_next = (y_head_ff == AR_IW'(MAX_AR - 1)) ? '0 : y_head_ff + 1'b1;
   assign e_next = (e_head_ff == MA_IW'(MAX_MA - 1)) ? '0 : e_head_ff + 1'b1;

   assign rsp_load = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      warmup_in    = warmup_ff;
      tap_in       = tap_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      y_head_in    = y_head_ff;
      e_head_in    = e_head_ff;
      y_ptr_in     = y_ptr_ff;
      e_ptr_in     = e_ptr_ff;
      noise_in     = noise_ff;
      value_in     = value_ff;
      sat_in       = sat_ff;
      last_in      = last_ff;
      produce_in   = produce_ff;
      mac_ctl      = '0;
      hist_rd_en   = 1'b0;
      hist_rd_addr = '0;
      coef_rd_addr = '0;
      hist_wr_en   = 1'b0;
      hist_wr_addr = '0;
      hist_wr_data = value_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               noise_in = req_noise_sample;
               last_in  = req_series_last;
               if (cnt_eff < q_eff) begin
                  // warm-up: store noise only
                  produce_in = 1'b0;
                  warmup_in  = cnt_eff + 1'b1;
                  state_in   = S_WR_E;
               end else if (cnt_eff < pq_sum) begin
                  // seed phase: emit the seed and store it
                  produce_in = 1'b1;
                  value_in   = req_seed_value;
                  sat_in     = 1'b0;
                  warmup_in  = cnt_eff + 1'b1;
                  state_in   = S_WR_Y;
               end else begin
                  produce_in  = 1'b1;
                  warmup_in   = cnt_eff;
                  mac_ctl.load = 1'b1;
                  tap_in      = '0;
                  p_in        = p_eff;
                  n_in        = pq_sum;
                  y_ptr_in    = y_head_ff;
                  e_ptr_in    = e_head_ff;
                  state_in    = (pq_sum == '0) ? S_DRAIN : S_ISSUE;
               end
               if (req_series_last) begin
                  warmup_in = '0;
               end
            end
         end
         S_ISSUE: begin
            // one tap read per cycle, newest history first
            mac_ctl.tap = 1'b1;
            hist_rd_en  = 1'b1;
            if (tap_ff < p_ff) begin
               coef_rd_addr = MEM_AW'(tap_ff);
               hist_rd_addr = MEM_AW'(y_ptr_ff);
               y_ptr_in     = (y_ptr_ff == '0) ? AR_IW'(MAX_AR - 1) : y_ptr_ff - 1'b1;
            end else begin
               mac_ctl.sub  = 1'b1;
               coef_rd_addr = MEM_AW'(MAX_AR) + MEM_AW'(tap_ff - p_ff);
               hist_rd_addr = MEM_AW'(MAX_AR) + MEM_AW'(e_ptr_ff);
               e_ptr_in     = (e_ptr_ff == '0) ? MA_IW'(MAX_MA - 1) : e_ptr_ff - 1'b1;
            end
            tap_in = tap_ff + 1'b1;
            if (tap_ff == n_ff - 1'b1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // wait for the last product to land in the accumulator
            if (!mac_busy) begin
               value_in = mac_result;
               sat_in   = mac_sat;
               state_in = S_WR_Y;
            end
         end
         S_WR_Y: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = MEM_AW'(y_next);
            hist_wr_data = value_ff;
            y_head_in    = y_next;
            state_in     = S_WR_E;
         end
         S_WR_E: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = MEM_AW'(MAX_AR) + MEM_AW'(e_next);
            hist_wr_data = noise_ff;
            e_head_in    = e_next;
            state_in     = produce_ff ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         warmup_ff  <= '0;
         tap_ff     <= '0;
         p_ff       <= '0;
         n_ff       <= '0;
         y_head_ff  <= '0;
         e_head_ff  <= '0;
         y_ptr_ff   <= '0;
         e_ptr_ff   <= '0;
         produce_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         warmup_ff  <= warmup_in;
         tap_ff     <= tap_in;
         p_ff       <= p_in;
         n_ff       <= n_in;
         y_head_ff  <= y_head_in;
         e_head_ff  <= e_head_in;
         y_ptr_ff   <= y_ptr_in;
         e_ptr_ff   <= e_ptr_in;
         produce_ff <= produce_in;
      end
   end

   // Item payload registers
   always_ff @(posedge clock) begin
      noise_ff <= noise_in;
      value_ff <= value_in;
      sat_ff   <= sat_in;
      last_ff  <= last_in;
   end

   // Output register: hold while stalled, drop once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= value_ff;
         rsp_sat_ff   <= sat_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_series_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_is_last      = rsp_last_ff;

   // Coefficients: AR taps from address 0, MA taps from address MAX_AR
   asg_ram #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (asg_pkg::COEF_W)
   ) u_coef_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (csr_wdata[asg_pkg::COEF_W-1:0]),
      .rd_en   (hist_rd_en),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   // Histories: output ring from address 0, noise ring from address MAX_AR
   asg_ram #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (SAMPLE_BITS)
   ) u_hist_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   asg_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .load_value (req_noise_sample),
      .coef       (coef_rd_data),
      .hist       (hist_rd_data),
      .busy       (mac_busy),
      .result     (mac_result),
      .saturated  (mac_sat)
   );

endmodule

### verif/series_check_pkg.sv
// Scoreboard for the ARMA series generator: register shadow, recursion predictor, result check.
`timescale 1ns / 1ps

package series_check_pkg;

   import asg_pkg::*;

   localparam int HIST_DEPTH = 8;

   typedef struct packed {
      logic [31:0] value;
      logic        saturated;
      logic        is_last;
   } series_out_t;

   class series_scoreboard;

      // shadow of the configuration registers and coefficient table
      logic [ORDER_W-1:0]       ar_order;
      logic [ORDER_W-1:0]       ma_order;
      logic [SLOT_W-1:0]        coef_select;
      logic signed [COEF_W-1:0] ar_coef [HIST_DEPTH];
      logic signed [COEF_W-1:0] ma_coef [HIST_DEPTH];

      // recursion state, newest entry at index 0
      logic signed [31:0] value_hist [HIST_DEPTH];
      logic signed [31:0] noise_hist [HIST_DEPTH];
      int                 warm_count;

      series_out_t expected_q [$];
      int errors;
      int accepted;
      int results;
      int sat_seen;

      function new();
         ar_order    = '0;
         ma_order    = '0;
         coef_select = '0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            ar_coef[i]    = '0;
            ma_coef[i]    = '0;
            value_hist[i] = '0;
            noise_hist[i] = '0;
         end
         warm_count = 0;
         errors     = 0;
         accepted   = 0;
         results    = 0;
         sat_seen   = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function int pending();
         return expected_q.size();
      endfunction

      // apply one register transfer
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_AR_ORDER: begin
               ar_order = data[ORDER_W-1:0];
            end
            CSR_MA_ORDER: begin
               ma_order = data[ORDER_W-1:0];
            end
            CSR_COEF_SELECT: begin
               coef_select = data[SLOT_W-1:0];
            end
            CSR_COEF_VALUE: begin
               if (coef_select < MA_SLOT_BASE)
                  ar_coef[coef_select[2:0]] = data;
               else
                  ma_coef[coef_select[2:0]] = data;
            end
            default: begin
            end
         endcase
      endfunction

      // shift the newest noise in, and the newest series value when one was made
      function void advance_history(logic with_value, logic signed [31:0] value,
                                    logic signed [31:0] noise);
         for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            noise_hist[i] = noise_hist[i-1];
            if (with_value)
               value_hist[i] = value_hist[i-1];
         end
         noise_hist[0] = noise;
         if (with_value)
            value_hist[0] = value;
      endfunction

      // predict the result of one accepted input transfer
      function void note_input(logic [31:0] noise_in, logic [31:0] seed_in,
                               logic start, logic last);
         int             p;
         int             q;
         longint         acc;
         longint         rounded;
         logic signed [31:0] noise;
         series_out_t    res;
         logic           produced;

         noise = noise_in;
         p = (ar_order > 4'd8) ? HIST_DEPTH : int'(ar_order);
         q = (ma_order > 4'd8) ? HIST_DEPTH : int'(ma_order);
         accepted++;
         produced      = 1'b1;
         res.saturated = 1'b0;
         res.is_last   = last;

         if (start)
            warm_count = 0;

         if (warm_count < q) begin
            // noise warm-up: no result
            advance_history(1'b0, '0, noise);
            warm_count++;
            produced = 1'b0;
         end else if (warm_count < q + p) begin
            // seed phase: emit the seed and feed it back
            res.value = seed_in;
            advance_history(1'b1, seed_in, noise);
            warm_count++;
         end else begin
            acc = longint'(noise) <<< 16;
            for (int j = 0; j < p; j++)
               acc = acc + longint'(ar_coef[j]) * longint'(value_hist[j]);
            for (int j = 0; j < q; j++)
               acc = acc - longint'(ma_coef[j]) * longint'(noise_hist[j]);
            rounded = (acc + 64'sd32768) >>> 16;
            if (rounded > 64'sd2147483647) begin
               rounded       = 64'sd2147483647;
               res.saturated = 1'b1;
            end else if (rounded < -64'sd2147483648) begin
               rounded       = -64'sd2147483648;
               res.saturated = 1'b1;
            end
            res.value = rounded[31:0];
            advance_history(1'b1, rounded[31:0], noise);
         end

         if (last)
            warm_count = 0;

         if (produced)
            expected_q.push_back(res);
      endfunction

      // compare one result transfer with the oldest prediction
      task check_result(logic [31:0] value, logic saturated, logic is_last);
         series_out_t exp_res;
         results++;
         if (saturated === 1'b1)
            sat_seen++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result value=%h sat=%b last=%b",
                             value, saturated, is_last));
            return;
         end
         exp_res = expected_q.pop_front();
         if (value !== exp_res.value)
            report($sformatf("result %0d series_value %h, predicted %h",
                             results, value, exp_res.value));
         if (saturated !== exp_res.saturated)
            report($sformatf("result %0d saturated %b, predicted %b",
                             results, saturated, exp_res.saturated));
         if (is_last !== exp_res.is_last)
            report($sformatf("result %0d is_last %b, predicted %b",
                             results, is_last, exp_res.is_last));
      endtask

   endclass

endpackage

### verif/tb_top.sv
// Top-level testbench for the ARMA series generator: clock, reset, drivers and phases.
`timescale 1ns / 1ps

module tb_top;

   import asg_pkg::*;
   import series_check_pkg::*;

   localparam int SAMPLE_BITS  = 32;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 30;
   localparam int PHASE_ITEMS  = 230;
   localparam int NUM_PHASES   = 8;

   // coefficient styles for a phase
   localparam int COEF_STABLE  = 0;
   localparam int COEF_WILD    = 1;
   localparam int COEF_EXTREME = 2;

   // first register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_COEF_VALUE + 1'b1;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_noise_sample;
   logic [SAMPLE_BITS-1:0] req_seed_value;
   logic                   req_series_start;
   logic                   req_series_last;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_series_value;
   logic                   rsp_saturated;
   logic                   rsp_is_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   series_scoreboard sb;
   int     gap_pct;
   int     stall_pct;
   int     series_count;
   longint cycles = 0;

   int phase_p    [NUM_PHASES] = '{0, 8, 3, 0, 15, 2, 9, 0};
   int phase_q    [NUM_PHASES] = '{0, 8, 0, 5, 12, 2, 1, 0};
   int phase_coef [NUM_PHASES] = '{COEF_STABLE, COEF_WILD, COEF_STABLE, COEF_STABLE,
                                   COEF_WILD, COEF_EXTREME, COEF_STABLE, COEF_STABLE};

   arma_series_generator #(
      .MAX_AR      (8),
      .MAX_MA      (8),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_noise_sample (req_noise_sample),
      .req_seed_value   (req_seed_value),
      .req_series_start (req_series_start),
      .req_series_last  (req_series_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_series_value (rsp_series_value),
      .rsp_saturated    (rsp_saturated),
      .rsp_is_last      (rsp_is_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // check result transfers, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_series_value, rsp_saturated, rsp_is_last);
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // mix of extremes, full-range and small values
   function automatic logic [31:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3, 4: return $urandom;
         default: return 32'($urandom_range(0, 2 * (1 << 20))) - 32'(1 << 20);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_coef(int style, int slot);
      if (style == COEF_EXTREME && slot % 8 == 0)
         return 18'h1_FFFF;
      if (style == COEF_EXTREME && slot % 8 == 1)
         return 18'h2_0000;
      if (style == COEF_WILD) begin
         case ($urandom_range(0, 3))
            0:       return 18'h2_0000;
            1:       return 18'h1_FFFF;
            default: return CSR_DATA_W'($urandom);
         endcase
      end
      // small taps keep the recursion from running away
      return CSR_DATA_W'($urandom_range(0, 12000)) - CSR_DATA_W'(6000);
   endfunction

   // present one item, hold it until the transfer
   task automatic send_item(logic [31:0] noise, logic [31:0] seed, logic start, logic last);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_noise_sample <= noise;
      req_seed_value   <= seed;
      req_series_start <= start;
      req_series_last  <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_input(noise, seed, start, last);
   endtask

   // one register transfer; valid stays high for a following write
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // drop valid, drain every predicted result, then let warm-up items settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(int p, int q, int style);
      logic [CSR_DATA_W-1:0] data;
      logic [CSR_IDX_W-1:0]  spare;
      wait_idle();
      data = CSR_DATA_W'($urandom);
      data[ORDER_W-1:0] = p[ORDER_W-1:0];
      csr_write(CSR_AR_ORDER, data);
      data = CSR_DATA_W'($urandom);
      data[ORDER_W-1:0] = q[ORDER_W-1:0];
      csr_write(CSR_MA_ORDER, data);
      for (int slot = 0; slot < 16; slot++) begin
         data = CSR_DATA_W'($urandom);
         data[SLOT_W-1:0] = slot[SLOT_W-1:0];
         csr_write(CSR_COEF_SELECT, data);
         csr_write(CSR_COEF_VALUE, rand_coef(style, slot));
      end
      // a write to an index with no register behind it must change nothing
      spare = CSR_FIRST_UNUSED + CSR_IDX_W'($urandom_range(0, 3));
      csr_write(spare, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed series, with stray start and last markers
   task automatic run_series(int n_items);
      int   sent;
      int   len;
      logic start;
      logic last;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 40);
         if ($urandom_range(0, 3) == 0)
            len = $urandom_range(1, 4);
         for (int k = 0; k < len && sent < n_items; k++) begin
            start = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
            last  = (k == len - 1) ? ($urandom_range(0, 9) != 0)
                                   : ($urandom_range(0, 49) == 0);
            send_item(rand_sample(), rand_sample(), start, last);
            sent++;
         end
         series_count++;
      end
   endtask

   initial begin
      sb           = new();
      gap_pct      = 0;
      stall_pct    = 0;
      series_count = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_noise_sample <= '0;
      req_seed_value   <= '0;
      req_series_start <= 1'b0;
      req_series_last  <= 1'b0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_AR_ORDER;
      csr_wdata        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // white noise after reset: extremes pass straight through
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
      send_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
      send_item(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
      send_item(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1);

      // ARMA(2,2) with extreme taps: warm-up, seeds, saturation both ways
      load_config(2, 2, COEF_EXTREME);
      send_item(32'h0000_0001, 32'h0000_0002, 1'b1, 1'b0);
      send_item(32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 1'b0);
      send_item(32'h0000_0005, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_item(32'h0000_0006, 32'h8000_0000, 1'b0, 1'b0);
      send_item(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
      send_item(32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_item(32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0);
      // restart mid-series, end during the seed phase
      send_item(32'h0000_0003, 32'h0000_0009, 1'b1, 1'b0);
      send_item(32'h0000_0004, 32'h0000_0009, 1'b0, 1'b0);
      send_item(32'h0000_0000, 32'h0000_0011, 1'b0, 1'b1);
      // end during the noise warm-up
      send_item(32'h0000_0002, 32'h0000_0022, 1'b0, 1'b0);
      send_item(32'h0000_0003, 32'h0000_0033, 1'b0, 1'b1);
      // full series without a start marker, histories carried over
      send_item(32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0);
      send_item(32'h0000_0002, 32'h0000_0002, 1'b0, 1'b0);
      send_item(32'h0000_0003, 32'h0000_0044, 1'b0, 1'b0);
      send_item(32'h0000_0004, 32'h0000_0055, 1'b0, 1'b0);
      send_item(32'h0000_0009, 32'h0000_0000, 1'b0, 1'b1);

      // random phases; open series run on across order changes
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == NUM_PHASES - 1) begin
            phase_p[ph] = $urandom_range(0, 15);
            phase_q[ph] = $urandom_range(0, 15);
         end
         load_config(phase_p[ph], phase_q[ph], phase_coef[ph]);
         case (ph % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 52;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 52;
            end
            default: begin
               gap_pct   = 37;
               stall_pct = 37;
            end
         endcase
         run_series(PHASE_ITEMS);
      end

      wait_idle();
      $display("Sent %0d items in %0d random series over %0d order settings",
               sb.accepted, series_count, NUM_PHASES + 2);
      $display("Checked %0d results, %0d of them clipped; %0d mismatches",
               sb.results, sb.sat_seen, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### files.f
hdl/asg_pkg.sv
hdl/asg_ram.sv
hdl/asg_mac.sv
hdl/arma_series_generator.sv
verif/series_check_pkg.sv
verif/tb_top.sv
